### sv/vfma_pkg.sv
// ----------------------------------------------------------------------------
// vfma_pkg
// Shared types, codes and operand tables for the moment accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package vfma_pkg;

   typedef enum logic [1:0] {
      FUNC_ACC   = 2'd0,
      FUNC_READ  = 2'd1,
      FUNC_CLEAR = 2'd2,
      FUNC_NONE  = 2'd3
   } func_type;

   localparam int MOMENTS     = 16;
   localparam int MOM_SECOND  = 6;   // ids below this are second order
   localparam int SQ_STEPS    = 4;   // xx, yy, zz, xy kept for third order
   localparam logic [3:0] MOM_LAST = 4'd15;

   localparam logic [1:0] SEL_X = 2'd0;
   localparam logic [1:0] SEL_Y = 2'd1;
   localparam logic [1:0] SEL_Z = 2'd2;

   // first fluctuation operand of a second-order moment
   function automatic logic [1:0] op_f_a(input logic [3:0] k);
      logic [1:0] r;
      case (k)
         4'd0, 4'd3, 4'd4: r = SEL_X;
         4'd1, 4'd5:       r = SEL_Y;
         4'd2:             r = SEL_Z;
         default:          r = SEL_X;
      endcase
      return r;
   endfunction

   // fluctuation operand multiplied last, for every moment
   function automatic logic [1:0] op_f_b(input logic [3:0] k);
      logic [1:0] r;
      case (k)
         4'd0, 4'd6, 4'd11, 4'd13:                       r = SEL_X;
         4'd1, 4'd3, 4'd7, 4'd9, 4'd14:                  r = SEL_Y;
         4'd2, 4'd4, 4'd5, 4'd8, 4'd10, 4'd12, 4'd15:    r = SEL_Z;
         default:                                        r = SEL_X;
      endcase
      return r;
   endfunction

   // stored second-order product used by a third-order moment
   function automatic logic [1:0] op_p(input logic [3:0] k);
      logic [1:0] r;
      case (k)
         4'd6, 4'd9, 4'd10:  r = 2'd0;
         4'd7, 4'd11, 4'd12: r = 2'd1;
         4'd8, 4'd13, 4'd14: r = 2'd2;
         4'd15:              r = 2'd3;
         default:            r = 2'd0;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

### sv/vfma_div.sv
// ----------------------------------------------------------------------------
// vfma_div
// Bit-serial signed 64-bit by unsigned 16-bit divider, truncating toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module vfma_div
   import vfma_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic signed [63:0] dividend,
   input  wire logic        [15:0] divisor,
   output logic                    done,
   output logic signed [63:0]      quotient
);

   logic        run_ff;
   logic [5:0]  cnt_ff;
   logic        neg_ff;
   logic [63:0] mag_ff;
   logic [15:0] dsr_ff;
   logic [15:0] rem_ff;
   logic        done_ff;
   logic [63:0] quo_ff;

   logic [16:0] trial;
   logic        fits;
   logic [63:0] mag_next;
   logic [15:0] rem_next;

   always_comb begin
      trial    = {rem_ff, mag_ff[63]};
      fits     = trial >= {1'b0, dsr_ff};
      rem_next = fits ? 16'(trial - {1'b0, dsr_ff}) : trial[15:0];
      mag_next = {mag_ff[62:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
            neg_ff <= dividend[63];
            mag_ff <= dividend[63] ? 64'(-dividend) : 64'(dividend);
            dsr_ff <= divisor;
            rem_ff <= '0;
         end else if (run_ff) begin
            mag_ff <= mag_next;
            rem_ff <= rem_next;
            cnt_ff <= cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
               quo_ff  <= neg_ff ? 64'(-mag_next) : mag_next;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

### sv/velocity_fluctuation_moment_accumulator.sv
// ----------------------------------------------------------------------------
// velocity_fluctuation_moment_accumulator
// Per-point second and third order velocity fluctuation moment accumulator.
// ----------------------------------------------------------------------------
// One transaction at a time: busy is high from acceptance until the work is
// done. An accumulate runs 4 squaring steps, then a multiply and an add state
// per moment, set by the single shared multiplier and the one memory port. A
// readout, when the point is in range and the snapshot count is nonzero, is
// set by the bit-serial divider (64 iterations plus the S_ORD and S_OSTART
// sequencing states per moment); otherwise it steps S_ORD once per moment and
// shows zeros. Results appear one per strobe and must be taken when shown.
// Clear, and reset, run a clearing pass over all POINTS*16 store words.
// An accumulate to an out-of-range point only counts its end mark and
// stays idle, so busy does not rise.
`default_nettype none

module velocity_fluctuation_moment_accumulator
   import vfma_pkg::*;
#(
   parameter int POINTS = 4096
)(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [1:0]         req_func,
   input  wire logic [11:0]        req_point,
   input  wire logic signed [15:0] req_vel_x,
   input  wire logic signed [15:0] req_vel_y,
   input  wire logic signed [15:0] req_vel_z,
   input  wire logic signed [15:0] req_mean_x,
   input  wire logic signed [15:0] req_mean_y,
   input  wire logic signed [15:0] req_mean_z,
   input  wire logic               req_end_of_snapshot,
   output logic                    rsp_strobe,
   output logic [3:0]              rsp_moment_id,
   output logic signed [63:0]      rsp_moment_value,
   output logic                    rsp_last
);

   localparam int PW    = (POINTS > 1) ? $clog2(POINTS) : 1;
   localparam int AW    = PW + 4;
   localparam int DEPTH = POINTS * MOMENTS;

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_SQ, S_MUL, S_ADD, S_ORD, S_OSTART, S_ODIV
   } state_type;

   state_type          state_ff;
   logic [AW-1:0]      clr_ff;
   logic [15:0]        count_ff;
   logic [PW-1:0]      point_ff;
   logic [3:0]         k_ff;
   logic               rd_ok_ff;
   logic signed [16:0] fx_ff, fy_ff, fz_ff;
   logic signed [33:0] p2_ff [SQ_STEPS];
   logic signed [63:0] prod_ff;
   logic signed [63:0] rd_data_ff;
   logic               strobe_ff;
   logic [3:0]         id_ff;
   logic signed [63:0] value_ff;
   logic               last_ff;

   logic signed [63:0] mem [DEPTH];

   logic               accept;
   logic               pt_valid;
   logic signed [16:0] fx_in, fy_in, fz_in;
   logic signed [34:0] mul_a;
   logic signed [16:0] mul_b;
   logic signed [51:0] mul_p;
   logic signed [64:0] sum;
   logic signed [63:0] sat;
   logic               mem_we;
   logic [AW-1:0]      mem_waddr;
   logic [AW-1:0]      mem_raddr;
   logic signed [63:0] mem_wdata;
   logic               div_start;
   logic               div_done;
   logic signed [63:0] div_q;

   function automatic logic signed [16:0] fsel(
      input logic [1:0] s, input logic signed [16:0] x,
      input logic signed [16:0] y, input logic signed [16:0] z);
      logic signed [16:0] r;
      case (s)
         SEL_X:   r = x;
         SEL_Y:   r = y;
         SEL_Z:   r = z;
         default: r = x;
      endcase
      return r;
   endfunction

   assign accept   = start && (state_ff == S_IDLE);
   assign pt_valid = 32'(req_point) < POINTS;
   assign fx_in    = {req_vel_x[15], req_vel_x} - {req_mean_x[15], req_mean_x};
   assign fy_in    = {req_vel_y[15], req_vel_y} - {req_mean_y[15], req_mean_y};
   assign fz_in    = {req_vel_z[15], req_vel_z} - {req_mean_z[15], req_mean_z};

   // shared multiplier: f*f for second order, stored square times f for third
   always_comb begin
      logic signed [16:0] fa;
      logic signed [33:0] pa;
      fa = fsel(op_f_a(k_ff), fx_ff, fy_ff, fz_ff);
      pa = p2_ff[op_p(k_ff)];
      if (state_ff == S_MUL && k_ff >= 4'(MOM_SECOND)) begin
         mul_a = {pa[33], pa};
      end else begin
         mul_a = {{18{fa[16]}}, fa};
      end
      mul_b = fsel(op_f_b(k_ff), fx_ff, fy_ff, fz_ff);
      mul_p = mul_a * mul_b;
   end

   always_comb begin
      sum = {rd_data_ff[63], rd_data_ff} + {prod_ff[63], prod_ff};
      if (sum[64] != sum[63]) begin
         sat = sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end else begin
         sat = sum[63:0];
      end
   end

   assign mem_raddr = {point_ff, k_ff};
   assign mem_we    = (state_ff == S_ADD) || (state_ff == S_CLEAR);
   assign mem_waddr = (state_ff == S_CLEAR) ? clr_ff : mem_raddr;
   assign mem_wdata = (state_ff == S_CLEAR) ? 64'sd0 : sat;
   assign div_start = (state_ff == S_OSTART);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_raddr];
   end

   vfma_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (rd_data_ff),
      .divisor  (count_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         clr_ff    <= '0;
         count_ff  <= '0;
         k_ff      <= '0;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= 1'b0;
         case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + AW'(1);
               if (clr_ff == AW'(DEPTH - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (accept) begin
                  point_ff <= PW'(req_point);
                  fx_ff    <= fx_in;
                  fy_ff    <= fy_in;
                  fz_ff    <= fz_in;
                  k_ff     <= '0;
                  rd_ok_ff <= pt_valid && (count_ff != 16'd0);
                  case (req_func)
                     FUNC_ACC: begin
                        if (req_end_of_snapshot && count_ff != 16'hFFFF) begin
                           count_ff <= count_ff + 16'd1;
                        end
                        if (pt_valid) begin
                           state_ff <= S_SQ;
                        end
                     end
                     FUNC_READ: state_ff <= S_ORD;
                     FUNC_CLEAR: begin
                        count_ff <= '0;
                        clr_ff   <= '0;
                        state_ff <= S_CLEAR;
                     end
                     default: state_ff <= S_IDLE;
                  endcase
               end
            end
            S_SQ: begin
               p2_ff[k_ff[1:0]] <= mul_p[33:0];
               if (k_ff == 4'(SQ_STEPS - 1)) begin
                  k_ff     <= '0;
                  state_ff <= S_MUL;
               end else begin
                  k_ff <= k_ff + 4'd1;
               end
            end
            S_MUL: begin
               prod_ff  <= 64'(mul_p);
               state_ff <= S_ADD;
            end
            S_ADD: begin
               k_ff <= k_ff + 4'd1;
               state_ff <= (k_ff == MOM_LAST) ? S_IDLE : S_MUL;
            end
            S_ORD: begin
               if (rd_ok_ff) begin
                  state_ff <= S_OSTART;
               end else begin
                  strobe_ff <= 1'b1;
                  id_ff     <= k_ff;
                  value_ff  <= '0;
                  last_ff   <= (k_ff == MOM_LAST);
                  k_ff      <= k_ff + 4'd1;
                  if (k_ff == MOM_LAST) begin
                     state_ff <= S_IDLE;
                  end
               end
            end
            S_OSTART: state_ff <= S_ODIV;
            S_ODIV: begin
               if (div_done) begin
                  strobe_ff <= 1'b1;
                  id_ff     <= k_ff;
                  value_ff  <= div_q;
                  last_ff   <= (k_ff == MOM_LAST);
                  k_ff      <= k_ff + 4'd1;
                  state_ff  <= (k_ff == MOM_LAST) ? S_IDLE : S_ORD;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy             = (state_ff != S_IDLE);
   assign rsp_strobe       = strobe_ff;
   assign rsp_moment_id    = id_ff;
   assign rsp_moment_value = value_ff;
   assign rsp_last         = last_ff;

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last |=> !rsp_strobe)
      else $error("result strobe right after last moment");

   a_read_busy: assert property (@(posedge clock) disable iff (reset)
      accept && req_func == FUNC_READ |=> busy)
      else $error("readout accepted but block not busy");

   a_write_state: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == S_ADD || state_ff == S_CLEAR))
      else $error("store written outside update or clearing pass");

   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_ODIV)
      else $error("divider finished while not awaited");

endmodule

`default_nettype wire
